/* src/triggered_sample_capture_buffer_defines.svh */
// ----------------------------------------------------------------------------
// Trace capture buffer assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TRIGGERED_SAMPLE_CAPTURE_BUFFER_DEFINES_SVH
`define TRIGGERED_SAMPLE_CAPTURE_BUFFER_DEFINES_SVH

// Same-cycle implication.
`define TSCB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TSCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/tscb_pkg.sv */
// ----------------------------------------------------------------------------
// Trace capture buffer package
// Item types, action and mode codes, register indexes and buffer sizing.
// ----------------------------------------------------------------------------
package tscb_pkg;

  localparam int unsigned BufferDepth     = 256;
  localparam int unsigned AddrW           = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;
  localparam int unsigned CountW          = $clog2(BufferDepth + 1);
  localparam int unsigned SampleWidthDef  = 64;
  localparam int unsigned WordW           = 64;
  localparam int unsigned CfgDataW        = 16;
  localparam int unsigned CfgIdxW         = 2;

  // Actions
  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_ARM   = 3'd1;
  localparam logic [2:0] ACT_STOP  = 3'd2;
  localparam logic [2:0] ACT_SEND  = 3'd3;
  localparam logic [2:0] ACT_SENT  = 3'd4;
  localparam logic [2:0] ACT_READ  = 3'd5;

  // Capture modes
  localparam logic [2:0] MODE_NOW           = 3'd0;
  localparam logic [2:0] MODE_START         = 3'd1;
  localparam logic [2:0] MODE_TRIG_START    = 3'd2;
  localparam logic [2:0] MODE_TRIG_FAULT    = 3'd3;
  localparam logic [2:0] MODE_SINGLE        = 3'd4;
  localparam logic [2:0] MODE_TRIG_START_NS = 3'd5;
  localparam logic [2:0] MODE_TRIG_FAULT_NS = 3'd6;
  localparam logic [2:0] MODE_INVALID       = 3'd7;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MODE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LENGTH = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DECIM  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_MOTOR  = 2'd3;

  typedef struct packed {
    logic [2:0]       action;
    logic [1:0]       motor_id;
    logic             pwm_on;
    logic             fault_active;
    logic [WordW-1:0] sample_word;
    logic [7:0]       read_index;
  } in_item_t;

  typedef struct packed {
    logic             accepted;
    logic             read_valid;
    logic [WordW-1:0] read_data;
    logic             capture_active;
    logic             capture_valid;
    logic             send_pending;
    logic [8:0]       sample_count;
    logic             capture_done;
  } out_item_t;

  // Status of one item, handed from the controller to the output stage
  typedef struct packed {
    logic       accepted;
    logic       read_valid;
    logic       capture_active;
    logic       capture_valid;
    logic       send_pending;
    logic [8:0] sample_count;
    logic       capture_done;
  } stat_t;

  // Sample store access of one item
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

/* src/triggered_sample_capture_buffer.sv */
// A result item appears in the cycle after its input item is accepted.
// Throughput: one item per cycle unless stalled; each item makes at most one
// access to the single sample store port pair (a write for a recorded tick, a read for a read).
// Reset: asynchronous, active low; clears control state and configuration,
// the sample store is left as is and needs no clearing pass.
// ----------------------------------------------------------------------------
// Triggered sample capture buffer
// Pre-trigger circular trace capture with decimation and send tracking.
// ----------------------------------------------------------------------------
module triggered_sample_capture_buffer #(
  parameter int unsigned SampleWidth = tscb_pkg::SampleWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tscb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tscb_pkg::CfgDataW-1:0] cfg_data_i,
  // Input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tscb_pkg::in_item_t            in_item_i,
  // Result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tscb_pkg::out_item_t           out_item_o
);

  logic                 accept;
  logic                 out_valid_q, out_valid_d;
  tscb_pkg::stat_t      stat, stat_q;
  tscb_pkg::mem_req_t   mem_req;
  logic [SampleWidth-1:0] rdata;

  // Configuration is taken at any time; the host must write only while idle (not enforced here)
  assign cfg_ready_o = 1'b1;

  // Stall only while a result item is held and the sink stalls
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Controller: all capture state updates and the store access happen at accept
  tscb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .mem_req_o   (mem_req),
    .stat_o      (stat)
  );

  // Sample store: read data lands with the result register and holds while
  // the result is stalled, since no new read is issued until it moves on
  tscb_mem #(
    .DataW (SampleWidth),
    .Depth (tscb_pkg::BufferDepth)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (in_item_i.sample_word[SampleWidth-1:0]),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  // Result register: load on accept, hold while stalled, drop when taken
  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stat_q <= stat;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    out_item_o                = '0;
    out_item_o.accepted       = stat_q.accepted;
    out_item_o.read_valid     = stat_q.read_valid;
    // Zero read data unless this item is a successful read
    out_item_o.read_data      = stat_q.read_valid ? tscb_pkg::WordW'(rdata) : '0;
    out_item_o.capture_active = stat_q.capture_active;
    out_item_o.capture_valid  = stat_q.capture_valid;
    out_item_o.send_pending   = stat_q.send_pending;
    out_item_o.sample_count   = stat_q.sample_count;
    out_item_o.capture_done   = stat_q.capture_done;
  end

endmodule

/* src/tscb_mem.sv */
// ----------------------------------------------------------------------------
// Trace capture sample store
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module tscb_mem #(
  parameter int unsigned DataW = tscb_pkg::SampleWidthDef,
  parameter int unsigned Depth = tscb_pkg::BufferDepth
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [DataW-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [DataW-1:0]                           rdata_o
);

  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* src/tscb_ctrl.sv */
// ----------------------------------------------------------------------------
// Trace capture controller
// Configuration registers, capture state, trigger detection and store access.
// ----------------------------------------------------------------------------
module tscb_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tscb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tscb_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           accept_i,
  input  tscb_pkg::in_item_t             item_i,
  output tscb_pkg::mem_req_t             mem_req_o,
  output tscb_pkg::stat_t                stat_o
);

  localparam int unsigned AW = tscb_pkg::AddrW;
  localparam int unsigned CW = tscb_pkg::CountW;

  typedef struct packed {
    logic active;
    logic armed;
    logic trig;
    logic valid;
    logic pend;
    logic auto_send;
    logic prev_run;
    logic prev_fault;
  } flags_t;

  // Configuration
  logic [2:0]  cfg_mode_q;
  logic [8:0]  cfg_len_q;
  logic [15:0] cfg_dec_q;
  logic [1:0]  cfg_motor_q;

  // Capture state
  logic [AW-1:0] wp_q, wp_d, oldest_q, oldest_d;
  logic [CW-1:0] vc_q, vc_d, len_q, len_d, post_q, post_d;
  logic [2:0]    mode_q, mode_d;
  logic [1:0]    motor_q, motor_d;
  logic [15:0]   dec_q, dec_d, dcnt_q, dcnt_d, dcnt_inc;
  flags_t        flg_q, flg_d;

  logic          running, run_rise, flt_rise, trig_mode, fault_mode;
  logic          hit, rec, fin;
  logic [CW-1:0] wp_inc, len_sel, rd_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mode_q  <= tscb_pkg::MODE_NOW;
      cfg_len_q   <= 9'(tscb_pkg::BufferDepth);
      cfg_dec_q   <= 16'd1;
      cfg_motor_q <= 2'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tscb_pkg::CFG_MODE:   cfg_mode_q  <= cfg_data_i[2:0];
        tscb_pkg::CFG_LENGTH: cfg_len_q   <= cfg_data_i[8:0];
        tscb_pkg::CFG_DECIM:  cfg_dec_q   <= cfg_data_i;
        tscb_pkg::CFG_MOTOR:  cfg_motor_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign running    = item_i.pwm_on & ~item_i.fault_active;
  assign run_rise   = running & ~flg_q.prev_run;
  assign flt_rise   = item_i.fault_active & ~flg_q.prev_fault;
  assign fault_mode = (mode_q == tscb_pkg::MODE_TRIG_FAULT) ||
                      (mode_q == tscb_pkg::MODE_TRIG_FAULT_NS);
  assign trig_mode  = fault_mode || (mode_q == tscb_pkg::MODE_TRIG_START) ||
                      (mode_q == tscb_pkg::MODE_TRIG_START_NS);
  assign dcnt_inc   = dcnt_q + 16'd1;
  assign len_sel    = ((cfg_len_q == 9'd0) || (CW'(cfg_len_q) > CW'(tscb_pkg::BufferDepth)))
                      ? CW'(tscb_pkg::BufferDepth) : CW'(cfg_len_q);
  // Logical to physical index: both terms stay below the length, so one subtract
  assign rd_sum     = CW'(oldest_q) + CW'(item_i.read_index);

  always_comb begin
    wp_d     = wp_q;
    oldest_d = oldest_q;
    vc_d     = vc_q;
    len_d    = len_q;
    post_d   = post_q;
    mode_d   = mode_q;
    motor_d  = motor_q;
    dec_d    = dec_q;
    dcnt_d   = dcnt_q;
    flg_d    = flg_q;
    hit      = 1'b0;
    rec      = 1'b0;
    fin      = 1'b0;
    wp_inc   = '0;
    mem_req_o = '0;
    stat_o    = '0;
    stat_o.accepted = 1'b1;

    if (accept_i) begin
      unique case (item_i.action)
        tscb_pkg::ACT_TICK: begin
          if (flg_q.active && (item_i.motor_id == motor_q)) begin
            flg_d.prev_run   = running;
            flg_d.prev_fault = item_i.fault_active;
            if (flg_q.armed && !flg_q.trig) begin
              if (fault_mode) begin
                hit = flt_rise;
              end else if ((mode_q == tscb_pkg::MODE_START) || trig_mode) begin
                hit = run_rise;
              end else begin
                hit = 1'b1;
              end
              if (hit) begin
                flg_d.trig  = 1'b1;
                flg_d.armed = 1'b0;
                if (mode_q == tscb_pkg::MODE_START) begin
                  wp_d     = '0;
                  vc_d     = '0;
                  oldest_d = '0;
                  post_d   = len_q;
                end else begin
                  post_d = CW'((len_q + CW'(1)) >> 1);
                end
              end
            end
            // Decimate, then record unless start mode still waits for its edge
            if (dcnt_inc < dec_q) begin
              dcnt_d = dcnt_inc;
            end else begin
              dcnt_d = '0;
              rec    = !((mode_q == tscb_pkg::MODE_START) && !flg_d.trig);
            end
            if (rec) begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = wp_d;
              wp_inc = CW'(wp_d) + CW'(1);
              wp_d   = (wp_inc >= len_q) ? '0 : wp_inc[AW-1:0];
              if (vc_d < len_q) begin
                vc_d = vc_d + CW'(1);
              end
              if (trig_mode || (mode_q == tscb_pkg::MODE_START)) begin
                if (flg_d.trig && (post_d != '0)) begin
                  post_d = post_d - CW'(1);
                  fin    = (post_d == '0);
                end
              end else begin
                fin = (vc_d >= len_q);
              end
            end
            if (fin) begin
              flg_d.active = 1'b0;
              flg_d.armed  = 1'b0;
              flg_d.valid  = (vc_d != '0);
              oldest_d     = (vc_d >= len_q) ? wp_d : '0;
              flg_d.pend   = flg_d.valid & flg_d.auto_send;
            end
          end
        end
        tscb_pkg::ACT_ARM: begin
          if ((cfg_mode_q == tscb_pkg::MODE_INVALID) || flg_q.pend) begin
            stat_o.accepted = 1'b0;
          end else begin
            motor_d  = cfg_motor_q;
            mode_d   = cfg_mode_q;
            len_d    = (cfg_mode_q == tscb_pkg::MODE_SINGLE) ? CW'(1) : len_sel;
            dec_d    = (cfg_dec_q == 16'd0) ? 16'd1 : cfg_dec_q;
            dcnt_d   = '0;
            wp_d     = '0;
            vc_d     = '0;
            oldest_d = '0;
            post_d   = '0;
            flg_d    = '0;
            flg_d.active    = 1'b1;
            flg_d.auto_send = (cfg_mode_q != tscb_pkg::MODE_TRIG_START_NS) &&
                              (cfg_mode_q != tscb_pkg::MODE_TRIG_FAULT_NS);
            flg_d.armed     = (cfg_mode_q != tscb_pkg::MODE_NOW) &&
                              (cfg_mode_q != tscb_pkg::MODE_SINGLE);
          end
        end
        tscb_pkg::ACT_STOP: begin
          flg_d.active = 1'b0;
          flg_d.armed  = 1'b0;
          flg_d.trig   = 1'b0;
          flg_d.pend   = 1'b0;
        end
        tscb_pkg::ACT_SEND: begin
          stat_o.accepted = flg_q.valid;
          if (flg_q.valid) begin
            flg_d.pend = 1'b1;
          end
        end
        tscb_pkg::ACT_SENT: begin
          flg_d.pend = 1'b0;
        end
        tscb_pkg::ACT_READ: begin
          if (flg_q.valid && (CW'(item_i.read_index) < vc_q)) begin
            stat_o.read_valid = 1'b1;
            mem_req_o.re      = 1'b1;
            mem_req_o.raddr   = (rd_sum >= len_q) ? AW'(rd_sum - len_q) : AW'(rd_sum);
          end
        end
        default: ;
      endcase
    end

    stat_o.capture_active = flg_d.active;
    stat_o.capture_valid  = flg_d.valid;
    stat_o.send_pending   = flg_d.pend;
    stat_o.sample_count   = 9'(vc_d);
    stat_o.capture_done   = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      oldest_q <= '0;
      vc_q     <= '0;
      len_q    <= CW'(tscb_pkg::BufferDepth);
      post_q   <= '0;
      mode_q   <= tscb_pkg::MODE_NOW;
      motor_q  <= 2'd0;
      dec_q    <= 16'd1;
      dcnt_q   <= '0;
      flg_q    <= '{auto_send: 1'b1, default: 1'b0};
    end else begin
      wp_q     <= wp_d;
      oldest_q <= oldest_d;
      vc_q     <= vc_d;
      len_q    <= len_d;
      post_q   <= post_d;
      mode_q   <= mode_d;
      motor_q  <= motor_d;
      dec_q    <= dec_d;
      dcnt_q   <= dcnt_d;
      flg_q    <= flg_d;
    end
  end

endmodule

/* src/tscb_chk.sv */
// ----------------------------------------------------------------------------
// Trace capture buffer port checker
// Watches the top level's ports for handshake and status consistency.
// ----------------------------------------------------------------------------
`include "triggered_sample_capture_buffer_defines.svh"

module tscb_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input tscb_pkg::out_item_t out_item_o
);

  // A stalled result item holds
  `TSCB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o), "stalled result item changed")

  // A finished capture and a running one never coexist
  `TSCB_ASSERT_NOW(a_valid_idle, out_valid_o, !(out_item_o.capture_active && out_item_o.capture_valid), "capture active and valid together")

  // Send pending only on a held capture
  `TSCB_ASSERT_NOW(a_pend_valid, out_valid_o && out_item_o.send_pending, out_item_o.capture_valid, "send pending without capture")

  // A successful read needs stored samples
  `TSCB_ASSERT_NOW(a_read_count, out_valid_o && out_item_o.read_valid, out_item_o.capture_valid && (out_item_o.sample_count != 9'd0), "read valid on empty capture")

  // Completion stops the capture
  `TSCB_ASSERT_NOW(a_done_stop, out_valid_o && out_item_o.capture_done, !out_item_o.capture_active, "capture done while still active")

endmodule

bind triggered_sample_capture_buffer tscb_chk u_tscb_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
